// ===== hw/rtl/usb_midi_descriptor_scanner_top_defines.svh =====
// assertion macros for the descriptor scanner rtl
`ifndef USB_MIDI_DESCRIPTOR_SCANNER_TOP_DEFINES_SVH
`define USB_MIDI_DESCRIPTOR_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define UMDS_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define UMDS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/umds_pkg.sv =====
// types and constants of the usb midi descriptor scanner
package umds_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MATCH_CLASS    = 1'b0,
    CFG_MATCH_SUBCLASS = 1'b1
  } cfg_index_t;

  localparam logic [7:0] MATCH_CLASS_RESET    = 8'h01;
  localparam logic [7:0] MATCH_SUBCLASS_RESET = 8'h03;

  // descriptor type codes
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

  // endpoint transfer type code for bulk
  localparam logic [1:0] XFER_BULK = 2'b10;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] match_class;
    logic [7:0] match_subclass;
  } match_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } desc_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  interface_number;
    logic [7:0]  alt_setting;
    logic [7:0]  endpoint_address;
    logic [10:0] max_packet;
  } scan_result_t;

  typedef struct packed {
    logic [15:0] byte_offset;
    logic [15:0] total_length;
    logic [15:0] record_start;
    logic [7:0]  record_length;
    logic [7:0]  record_type;
    logic        record_checked;
    logic        in_match;
    logic [15:0] held_if;
    logic [31:0] held_ep;
    logic [7:0]  held_byte6;
    logic        walk_done;
  } walk_state_t;

endpackage

// ===== hw/rtl/umds_if.sv =====
// request channels of the descriptor scanner
interface umds_desc_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink (input valid, data_byte, first_byte, output ready);
endinterface

interface umds_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  interface_number;
  logic [7:0]  alt_setting;
  logic [7:0]  endpoint_address;
  logic [10:0] max_packet;

  modport source (output valid, status, interface_number, alt_setting, endpoint_address,
                  max_packet, input ready);
  modport sink (input valid, status, interface_number, alt_setting, endpoint_address,
                max_packet, output ready);
endinterface

// ===== hw/rtl/umds_in_stage.sv =====
// input register for descriptor byte requests
module umds_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  umds_desc_if.sink             desc,
  input  logic                  advance,
  output logic                  item_valid,
  output umds_pkg::desc_item_t  item
);

  logic valid_q;

  // take a new request when empty or whenever the held one moves on
  assign desc.ready = !valid_q || advance;
  assign item_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (desc.ready) begin
      valid_q <= desc.valid;
    end
    if (desc.valid && desc.ready) begin
      item.data_byte  <= desc.data_byte;
      item.first_byte <= desc.first_byte;
    end
  end

endmodule

// ===== hw/rtl/umds_out_stage.sv =====
// result register toward the receiver
module umds_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  umds_pkg::scan_result_t  res,
  output logic                    slot_free,
  umds_result_if.source           result
);

  logic                   valid_q;
  umds_pkg::scan_result_t res_q;

  assign slot_free = !valid_q || result.ready;

  // hold a result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (result.ready) begin
      valid_q <= 1'b0;
    end
    if (load) begin
      res_q <= res;
    end
  end

  assign result.valid            = valid_q;
  assign result.status           = res_q.status;
  assign result.interface_number = res_q.interface_number;
  assign result.alt_setting      = res_q.alt_setting;
  assign result.endpoint_address = res_q.endpoint_address;
  assign result.max_packet       = res_q.max_packet;

endmodule

// ===== hw/rtl/umds_walk.sv =====
// per-byte descriptor walk: state registers and next-state logic
`include "usb_midi_descriptor_scanner_top_defines.svh"

module umds_walk (
  input  logic                    clk,
  input  logic                    rst,
  input  umds_pkg::match_cfg_t    cfg,
  input  logic                    advance,
  input  umds_pkg::desc_item_t    item,
  output logic                    res_load,
  output umds_pkg::scan_result_t  res
);

  // walk idle until a first byte, everything else cleared
  localparam umds_pkg::walk_state_t WALK_RESET = '{walk_done: 1'b1, default: '0};

  umds_pkg::walk_state_t state_q;
  umds_pkg::walk_state_t cur;
  umds_pkg::walk_state_t state_next;
  umds_pkg::status_t     fin_status;

  logic        active;
  logic        finish;
  logic        go;
  logic        if_match;
  logic        ep_hit;
  logic [7:0]  b;
  logic [15:0] rel;
  logic [16:0] have;
  logic [16:0] t17;
  logic [16:0] start2;
  logic [16:0] rec_end;
  logic [15:0] t;
  logic [7:0]  len0;
  logic [7:0]  tlo;
  logic [7:0]  thi;
  logic [16:0] chk_end;
  logic [16:0] chk_total;

  always_comb begin
    // a first byte restarts the walk from a clean state
    cur = state_q;
    if (item.first_byte) begin
      cur = '0;
    end
    active     = !cur.walk_done;
    b          = item.data_byte;
    state_next = cur;
    finish     = 1'b0;
    fin_status = umds_pkg::ST_NOT_FOUND;
    go         = 1'b0;
    if_match   = 1'b0;
    ep_hit     = 1'b0;

    // total length from bytes 2 and 3
    if (cur.byte_offset == 16'd2) begin
      state_next.total_length[7:0] = b;
    end else if (cur.byte_offset == 16'd3) begin
      state_next.total_length[15:8] = b;
    end

    // capture record bytes by position within the record
    rel = cur.byte_offset - cur.record_start;
    if (cur.byte_offset >= cur.record_start) begin
      unique case (rel)
        16'd0: begin
          state_next.record_length = b;
        end
        16'd1: begin
          state_next.record_type = b;
        end
        16'd2: begin
          state_next.held_ep[7:0] = b;
        end
        16'd3: begin
          state_next.held_ep[15:8] = b;
        end
        16'd4: begin
          state_next.held_ep[23:16] = b;
        end
        16'd5: begin
          state_next.held_ep[31:24] = b;
        end
        16'd6: begin
          state_next.held_byte6 = b;
        end
        default: ;
      endcase
    end

    have = {1'b0, cur.byte_offset} + 17'd1;
    state_next.byte_offset = (cur.byte_offset == 16'hFFFF) ? 16'hFFFF : have[15:0];

    t       = state_next.total_length;
    t17     = {1'b0, t};
    len0    = state_next.record_length;
    tlo     = t[7:0];
    thi     = t[15:8];
    start2  = {1'b0, cur.record_start} + 17'd2;
    rec_end = {1'b0, cur.record_start} + {9'd0, state_next.record_length};

    if (cur.byte_offset == 16'd3) begin
      // total now known: settle the records that began in the first four bytes
      if (t < 16'd2) begin
        finish = 1'b1;
      end else if (len0 < 8'd2 || {8'd0, len0} > t) begin
        finish     = 1'b1;
        fin_status = umds_pkg::ST_MALFORMED;
      end else if (len0 > 8'd4) begin
        state_next.record_checked = 1'b1;
      end else if (len0 == 8'd4) begin
        if (t < 16'd6) begin
          finish = 1'b1;
        end else begin
          state_next.record_start   = 16'd4;
          state_next.record_checked = 1'b0;
        end
      end else if (len0 == 8'd3) begin
        // next record starts on the high length byte
        if (t < 16'd5) begin
          finish = 1'b1;
        end else if (thi < 8'd2 || ({8'd0, thi} + 16'd3) > t) begin
          finish     = 1'b1;
          fin_status = umds_pkg::ST_MALFORMED;
        end else begin
          state_next.record_start   = 16'd3;
          state_next.record_length  = thi;
          state_next.record_checked = 1'b1;
        end
      end else begin
        // next record starts on the low length byte
        state_next.record_length = tlo;
        state_next.record_type   = thi;
        if (t < 16'd4) begin
          finish = 1'b1;
        end else if (tlo < 8'd2 || ({8'd0, tlo} + 16'd2) > t) begin
          finish     = 1'b1;
          fin_status = umds_pkg::ST_MALFORMED;
        end else if (tlo == 8'd2) begin
          if (t < 16'd6) begin
            finish = 1'b1;
          end else begin
            state_next.record_start   = 16'd4;
            state_next.record_checked = 1'b0;
          end
        end else begin
          state_next.record_start   = 16'd2;
          state_next.record_checked = 1'b1;
        end
      end
    end else if (cur.byte_offset >= 16'd4) begin
      // length checks on the first byte of a record
      go = 1'b1;
      if (!cur.record_checked) begin
        if (start2 > t17) begin
          finish = 1'b1;
          go     = 1'b0;
        end else if (have <= {1'b0, cur.record_start}) begin
          go = 1'b0;
        end else if (state_next.record_length < 8'd2 || rec_end > t17) begin
          finish     = 1'b1;
          fin_status = umds_pkg::ST_MALFORMED;
          go         = 1'b0;
        end else begin
          state_next.record_checked = 1'b1;
        end
      end
      // record complete: act on it and step to the next one
      if (go && state_next.record_checked && have >= rec_end) begin
        if (state_next.record_type == umds_pkg::TYPE_INTERFACE &&
            state_next.record_length >= 8'd9) begin
          if_match = (state_next.held_ep[31:24] == cfg.match_class) &&
                     (state_next.held_byte6 == cfg.match_subclass);
          state_next.in_match = if_match;
          state_next.held_if  = if_match ? state_next.held_ep[15:0] : 16'd0;
        end else if (state_next.record_type == umds_pkg::TYPE_ENDPOINT && cur.in_match &&
                     state_next.record_length >= 8'd7) begin
          ep_hit = (state_next.held_ep[9:8] == umds_pkg::XFER_BULK) && state_next.held_ep[7];
        end
        if (ep_hit) begin
          finish     = 1'b1;
          fin_status = umds_pkg::ST_FOUND;
        end else begin
          state_next.record_start   = rec_end[15:0];
          state_next.record_checked = 1'b0;
          if ((rec_end + 17'd2) > t17) begin
            finish = 1'b1;
          end
        end
      end
    end

    if (finish) begin
      state_next.walk_done = 1'b1;
    end
    if (!active) begin
      state_next = state_q;
      finish     = 1'b0;
    end
  end

  // result fields are zero unless an endpoint was found
  always_comb begin
    res.status           = fin_status;
    res.interface_number = 8'd0;
    res.alt_setting      = 8'd0;
    res.endpoint_address = 8'd0;
    res.max_packet       = 11'd0;
    if (fin_status == umds_pkg::ST_FOUND) begin
      res.interface_number = cur.held_if[7:0];
      res.alt_setting      = cur.held_if[15:8];
      res.endpoint_address = state_next.held_ep[7:0];
      res.max_packet       = state_next.held_ep[26:16];
    end
  end

  assign res_load = advance && finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= WALK_RESET;
    end else if (advance) begin
      state_q <= state_next;
    end
  end

  // checked records never reach past the total
  assign chk_end   = {1'b0, state_q.record_start} + {9'd0, state_q.record_length};
  assign chk_total = {1'b0, state_q.total_length};

  `UMDS_ASSERT_NEXT(a_done_after_result, clk, rst, res_load, state_q.walk_done,
                    "walk still running after a result")
  `UMDS_ASSERT_NEXT(a_offset_moves, clk, rst,
                    advance && (item.first_byte || !state_q.walk_done),
                    state_q.byte_offset != 16'd0, "byte offset did not advance")
  `UMDS_ASSERT_IMPLY(a_record_in_bounds, clk, rst,
                     !state_q.walk_done && state_q.byte_offset >= 16'd4 &&
                     state_q.record_checked,
                     chk_end <= chk_total, "checked record overruns total length")

endmodule

// ===== hw/rtl/usb_midi_descriptor_scanner_top.sv =====
// usb midi descriptor scanner: top level
//
// The desc channel takes one configuration descriptor byte per request, with
// first_byte marking offset 0 of a new block. The result channel gives one
// request per block: found with the interface number, alternate setting,
// bulk IN endpoint address and max packet size, or not found, or malformed.
// Bytes before the first first_byte, and bytes after a block's result, are
// absorbed and give nothing.
// Throughput is one byte per cycle unless a pending result stalls it; the walk
// state is updated by a single pass of logic between the input register and the
// result register. The byte that ends the walk is held in the input register and
// its result is registered in the result register. A result waiting in the result
// register holds the byte in the input register, so while the receiver stalls with
// a result pending the input takes at most one more byte and then drops ready.
// The user writes the match class and subclass registers through wr_en, wr_index
// and wr_data only while the block is idle; the block does not enforce this.
// Reset is synchronous: both stages empty, walk idle until a first byte,
// match class 0x01 and subclass 0x03.
module usb_midi_descriptor_scanner_top (
  input  logic                                clk,
  input  logic                                rst,
  umds_desc_if.sink                           desc,
  umds_result_if.source                       result,
  input  logic                                wr_en,
  input  logic [umds_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [umds_pkg::CFG_DATA_W-1:0]     wr_data
);

  umds_pkg::match_cfg_t   cfg;
  umds_pkg::desc_item_t   item;
  umds_pkg::scan_result_t res;
  logic                   advance;
  logic                   res_load;
  logic                   item_valid;
  logic                   slot_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_class    <= umds_pkg::MATCH_CLASS_RESET;
      cfg.match_subclass <= umds_pkg::MATCH_SUBCLASS_RESET;
    end else if (wr_en) begin
      if (wr_index == umds_pkg::CFG_MATCH_CLASS) begin
        cfg.match_class <= wr_data;
      end else if (wr_index == umds_pkg::CFG_MATCH_SUBCLASS) begin
        cfg.match_subclass <= wr_data;
      end
    end
  end

  // a held byte moves on when the result slot can take its outcome
  assign advance = item_valid && slot_free;

  umds_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .desc       (desc),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  umds_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .advance  (advance),
    .item     (item),
    .res_load (res_load),
    .res      (res)
  );

  umds_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .slot_free (slot_free),
    .result    (result)
  );

endmodule
